[rtl/mfu_pkg.sv]
// Package for the motor feedback unwrap filter: constants and the per-motor state type.
`timescale 1ns / 1ps

package mfu_pkg;

    localparam int MOTOR_COUNT_DEF = 4;

    localparam logic [10:0] ID_BASE = 11'h201;

    localparam logic signed [31:0] ENC_COUNTS  = 32'sd8192;
    localparam logic signed [15:0] HIGH_THRESH = 16'sd5460;
    localparam logic signed [15:0] LOW_THRESH  = 16'sd2730;

    localparam logic [15:0] WEIGHT_RESET = 16'd655;

    typedef struct packed {
        logic signed [15:0] last_angle;
        logic signed [31:0] turn_position;
        logic signed [31:0] smoothed_speed;
    } motor_state_t;

    localparam int STATE_W = $bits(motor_state_t);

endpackage

[rtl/mfu_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mfu_update.sv]
// Per-motor update: multi-turn angle unwrap and exponential speed filter.
`timescale 1ns / 1ps

module mfu_update (
    input  mfu_pkg::motor_state_t old_state,
    input  logic signed [15:0]    angle_value,
    input  logic [15:0]           weight,
    input  logic signed [32:0]    weighted_speed,
    output mfu_pkg::motor_state_t new_state
);

    logic signed [31:0] angle_ext;
    logic signed [31:0] last_ext;
    logic signed [31:0] turn_adj;
    logic               wrap_up;
    logic               wrap_down;
    logic signed [48:0] decay_prod;
    logic signed [49:0] decay_neg;
    logic signed [33:0] decay_shifted;
    logic signed [33:0] filter_sum;

    assign angle_ext = {{16{angle_value[15]}}, angle_value};
    assign last_ext  = {{16{old_state.last_angle[15]}}, old_state.last_angle};

    assign wrap_up   = (old_state.last_angle > mfu_pkg::HIGH_THRESH)
                       && (angle_value < mfu_pkg::LOW_THRESH);
    assign wrap_down = (old_state.last_angle < mfu_pkg::LOW_THRESH)
                       && (angle_value > mfu_pkg::HIGH_THRESH);

    always_comb
    begin
        turn_adj = 32'sd0;
        if (wrap_up)
        begin
            turn_adj = mfu_pkg::ENC_COUNTS;
        end
        else if (wrap_down)
        begin
            turn_adj = -mfu_pkg::ENC_COUNTS;
        end
    end

    // The filter is rewritten as w*speed + old + floor(-w*old / 65536).
    assign decay_prod    = $signed({{32{1'b0}}, weight})
                           * $signed({{17{old_state.smoothed_speed[31]}},
                                      old_state.smoothed_speed});
    assign decay_neg     = 50'sd0 - $signed({decay_prod[48], decay_prod});
    assign decay_shifted = decay_neg[49:16];
    assign filter_sum    = $signed({weighted_speed[32], weighted_speed})
                           + $signed({{2{old_state.smoothed_speed[31]}},
                                      old_state.smoothed_speed})
                           + decay_shifted;

    always_comb
    begin
        new_state.last_angle     = angle_value;
        new_state.turn_position  = old_state.turn_position + (angle_ext - last_ext) + turn_adj;
        new_state.smoothed_speed = filter_sum[31:0];
    end

endmodule

[rtl/motor_feedback_unwrap_filter.sv]
// Top level of the motor feedback unwrap filter: decode, state memory and output register.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    frame_id, angle_value, speed_value, torque_value
//   output    out_valid / out_ready  motor_index, position, angle, speed,
//                                    filtered_speed, torque
//   config    cfg_valid / cfg_ready  filter_weight
//
// One item is taken every cycle while the output is not stalled; the state memory is read in the
// accept cycle and written back as the item leaves the update stage for the output register;
// a write-back register forwards the latest update to a following item for the same motor.
// Reset clears the entry valid bits, so every motor reads as zero until first updated.
// Items with an unknown identifier are accepted and dropped. A stalled output holds its item,
// and the input keeps accepting while the output register is free or being emptied.
`timescale 1ns / 1ps

module motor_feedback_unwrap_filter #(
    parameter int MOTOR_COUNT = mfu_pkg::MOTOR_COUNT_DEF,
    parameter int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         filter_weight,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [10:0]         frame_id,
    input  logic signed [15:0]  angle_value,
    input  logic signed [15:0]  speed_value,
    input  logic signed [15:0]  torque_value,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    motor_index,
    output logic signed [31:0]  position,
    output logic signed [15:0]  angle,
    output logic signed [15:0]  speed,
    output logic signed [31:0]  filtered_speed,
    output logic signed [15:0]  torque
);

    logic [15:0]               weight_reg;

    logic [10:0]               id_offset;
    logic                      id_hit;
    logic [IDX_W-1:0]          id_index;
    logic                      in_accept;

    logic                      s1_valid_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic signed [15:0]        s1_angle_reg;
    logic signed [15:0]        s1_speed_reg;
    logic signed [15:0]        s1_torque_reg;
    logic signed [32:0]        s1_wspeed_reg;
    logic                      s1_advance;

    logic [MOTOR_COUNT-1:0]    entry_valid_reg;
    logic                      fwd_valid_reg;
    logic [IDX_W-1:0]          fwd_idx_reg;
    mfu_pkg::motor_state_t     fwd_state_reg;

    logic [mfu_pkg::STATE_W-1:0] ram_rdata;
    mfu_pkg::motor_state_t     old_state;
    mfu_pkg::motor_state_t     new_state;

    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic signed [31:0]        out_pos_reg;
    logic signed [15:0]        out_angle_reg;
    logic signed [15:0]        out_speed_reg;
    logic signed [31:0]        out_filt_reg;
    logic signed [15:0]        out_torque_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= mfu_pkg::WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            weight_reg <= filter_weight;
        end
    end

    assign id_offset = frame_id - mfu_pkg::ID_BASE;
    assign id_hit    = (frame_id >= mfu_pkg::ID_BASE) && ({21'd0, id_offset} < MOTOR_COUNT);
    assign id_index  = id_offset[IDX_W-1:0];

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= id_hit;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_idx_reg    <= id_index;
            s1_angle_reg  <= angle_value;
            s1_speed_reg  <= speed_value;
            s1_torque_reg <= torque_value;
            s1_wspeed_reg <= $signed({17'd0, weight_reg})
                             * $signed({{17{speed_value[15]}}, speed_value});
        end
    end

    mfu_ram #(
        .WIDTH (mfu_pkg::STATE_W),
        .DEPTH (MOTOR_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_idx_reg),
        .wdata (new_state),
        .re    (in_accept),
        .raddr (id_index),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            old_state = fwd_state_reg;
        end
        else if (entry_valid_reg[s1_idx_reg])
        begin
            old_state = ram_rdata;
        end
        else
        begin
            old_state = '0;
        end
    end

    mfu_update u_update (
        .old_state      (old_state),
        .angle_value    (s1_angle_reg),
        .weight         (weight_reg),
        .weighted_speed (s1_wspeed_reg),
        .new_state      (new_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (s1_advance)
        begin
            entry_valid_reg[s1_idx_reg] <= 1'b1;
            fwd_valid_reg               <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            fwd_idx_reg   <= s1_idx_reg;
            fwd_state_reg <= new_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_idx_reg    <= s1_idx_reg;
            out_pos_reg    <= new_state.turn_position;
            out_angle_reg  <= s1_angle_reg;
            out_speed_reg  <= s1_speed_reg;
            out_filt_reg   <= new_state.smoothed_speed;
            out_torque_reg <= s1_torque_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign motor_index    = out_idx_reg;
    assign position       = out_pos_reg;
    assign angle          = out_angle_reg;
    assign speed          = out_speed_reg;
    assign filtered_speed = out_filt_reg;
    assign torque         = out_torque_reg;

    // An item with an unknown identifier leaves the update stage empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !id_hit |=> !s1_valid_reg)
    else $error("dropped item entered the update stage");

    // A known identifier reaches the update stage with its motor number.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && id_hit |=> s1_valid_reg && (s1_idx_reg == $past(id_index)))
    else $error("update stage does not hold the accepted motor");

    // A held update stage keeps its item while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_idx_reg))
    else $error("update stage lost its item during a stall");

    // A write-back marks the entry valid and is the one forwarded next.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> entry_valid_reg[$past(s1_idx_reg)] && fwd_valid_reg
                       && (fwd_idx_reg == $past(s1_idx_reg)))
    else $error("write-back not recorded for forwarding");

    // Every write-back produces a result item in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg && (out_idx_reg == $past(s1_idx_reg)))
    else $error("write-back without a result item");

endmodule

[tb/mfu_feedback_checker.sv]
// Checker for the motor feedback unwrap filter: predicts each motor update and compares results.
`timescale 1ns / 1ps

module mfu_feedback_checker (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [15:0]        filter_weight,

    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [10:0]        frame_id,
    input  logic signed [15:0] angle_value,
    input  logic signed [15:0] speed_value,
    input  logic signed [15:0] torque_value,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         motor_index,
    input  logic signed [31:0] position,
    input  logic signed [15:0] angle,
    input  logic signed [15:0] speed,
    input  logic signed [31:0] filtered_speed,
    input  logic signed [15:0] torque,

    output int                 pending_updates,
    output int                 fail_count
);

    typedef struct packed {
        logic [1:0]         motor_index;
        logic signed [31:0] position;
        logic signed [15:0] angle;
        logic signed [15:0] speed;
        logic signed [31:0] filtered_speed;
        logic signed [15:0] torque;
    } motor_update_t;

    logic [15:0]        weight;
    logic signed [15:0] prev_angle [mfu_pkg::MOTOR_COUNT_DEF];
    logic signed [31:0] turn_count [mfu_pkg::MOTOR_COUNT_DEF];
    logic signed [31:0] speed_avg  [mfu_pkg::MOTOR_COUNT_DEF];
    motor_update_t      expected_updates [$];

    initial
    begin
        fail_count = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic motor_update_t unwrap_and_filter(input int m,
                                                        input logic signed [15:0] ang,
                                                        input logic signed [15:0] spd,
                                                        input logic signed [15:0] trq);
        motor_update_t      upd;
        logic signed [31:0] pos;
        longint             acc;
        longint             filt;
        pos = turn_count[m] + (int'(ang) - int'(prev_angle[m]));
        if (prev_angle[m] > mfu_pkg::HIGH_THRESH && ang < mfu_pkg::LOW_THRESH)
            pos = pos + mfu_pkg::ENC_COUNTS;
        else if (prev_angle[m] < mfu_pkg::LOW_THRESH && ang > mfu_pkg::HIGH_THRESH)
            pos = pos - mfu_pkg::ENC_COUNTS;
        acc = longint'(weight) * longint'(spd) * 64'sd65536
            + (64'sd65536 - longint'(weight)) * longint'(speed_avg[m]);
        filt = acc >>> 16;
        turn_count[m] = pos;
        prev_angle[m] = ang;
        speed_avg[m]  = filt[31:0];
        upd.motor_index    = m[1:0];
        upd.position       = pos;
        upd.angle          = ang;
        upd.speed          = spd;
        upd.filtered_speed = filt[31:0];
        upd.torque         = trq;
        return upd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        motor_update_t want;
        int            m;
        if (!rst_n)
        begin
            weight = mfu_pkg::WEIGHT_RESET;
            for (int i = 0; i < mfu_pkg::MOTOR_COUNT_DEF; i++)
            begin
                prev_angle[i] = '0;
                turn_count[i] = '0;
                speed_avg[i]  = '0;
            end
            expected_updates.delete();
            pending_updates <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_updates.size() == 0)
                    report_mismatch("result item arrived with no frame outstanding");
                else
                begin
                    want = expected_updates.pop_front();
                    check_field("motor_index", motor_index, want.motor_index);
                    check_field("position", position, want.position);
                    check_field("angle", angle, want.angle);
                    check_field("speed", speed, want.speed);
                    check_field("filtered_speed", filtered_speed, want.filtered_speed);
                    check_field("torque", torque, want.torque);
                end
            end
            if (cfg_valid && cfg_ready)
                weight = filter_weight;
            if (in_valid && in_ready)
            begin
                m = int'(frame_id) - int'(mfu_pkg::ID_BASE);
                if (m >= 0 && m < mfu_pkg::MOTOR_COUNT_DEF)
                    expected_updates.push_back(
                        unwrap_and_filter(m, angle_value, speed_value, torque_value));
            end
            pending_updates <= expected_updates.size();
        end
    end

endmodule

[tb/motor_feedback_unwrap_filter_tb.sv]
// Testbench top for the motor feedback unwrap filter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module motor_feedback_unwrap_filter_tb;

    localparam int LIMIT       = 200000;
    localparam int PHASES      = 6;
    localparam int PER_PHASE   = 242;
    localparam int HOLD_CYCLES = 80;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        filter_weight;
    logic               in_valid;
    logic               in_ready;
    logic [10:0]        frame_id;
    logic signed [15:0] angle_value;
    logic signed [15:0] speed_value;
    logic signed [15:0] torque_value;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         motor_index;
    logic signed [31:0] position;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [31:0] filtered_speed;
    logic signed [15:0] torque;

    int                 pending_updates;
    int                 fail_count;
    int                 cycles = 0;
    int                 tx_idle_pct = 25;
    int                 rx_idle_pct = 25;
    logic               hold_req = 1'b0;
    logic               hold_off = 1'b0;

    logic [15:0]        phase_weight [PHASES] = '{16'd0, 16'd65535, 16'd1, 16'd32768,
                                                  16'd0, 16'd655};
    logic signed [15:0] motor_angle [mfu_pkg::MOTOR_COUNT_DEF];
    logic signed [15:0] speed_pick [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    logic [10:0]        id;
    logic signed [15:0] ang;
    logic signed [15:0] spd;
    int                 sent;
    int                 m;
    int                 roll;
    int                 step_ang;

    motor_feedback_unwrap_filter u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .filter_weight  (filter_weight),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_id       (frame_id),
        .angle_value    (angle_value),
        .speed_value    (speed_value),
        .torque_value   (torque_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .motor_index    (motor_index),
        .position       (position),
        .angle          (angle),
        .speed          (speed),
        .filtered_speed (filtered_speed),
        .torque         (torque)
    );

    mfu_feedback_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .filter_weight   (filter_weight),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .frame_id        (frame_id),
        .angle_value     (angle_value),
        .speed_value     (speed_value),
        .torque_value    (torque_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .motor_index     (motor_index),
        .position        (position),
        .angle           (angle),
        .speed           (speed),
        .filtered_speed  (filtered_speed),
        .torque          (torque),
        .pending_updates (pending_updates),
        .fail_count      (fail_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_frame(input logic [10:0] fid, input logic signed [15:0] a,
                              input logic signed [15:0] s, input logic signed [15:0] t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        frame_id     <= fid;
        angle_value  <= a;
        speed_value  <= s;
        torque_value <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_updates != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_weight(input logic [15:0] w);
        cfg_valid     <= 1'b1;
        filter_weight <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        filter_weight <= mfu_pkg::WEIGHT_RESET;
        in_valid      <= 1'b0;
        frame_id      <= '0;
        angle_value   <= '0;
        speed_value   <= '0;
        torque_value  <= '0;
        for (int i = 0; i < mfu_pkg::MOTOR_COUNT_DEF; i++)
            motor_angle[i] = '0;
        phase_weight[4] = 16'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unknown identifiers, first-frame jumps, both wrap directions and the threshold edges.
        send_frame(11'h000, 16'sd0, 16'sd0, 16'sd0);
        send_frame(11'h200, 16'sd100, 16'sd5, 16'sd5);
        send_frame(11'h205, 16'sd100, 16'sd5, 16'sd5);
        send_frame(11'h7FF, -16'sd1, -16'sd1, -16'sd1);
        send_frame(11'h201, 16'sd8000, 16'sh7FFF, 16'sh7FFF);
        send_frame(11'h201, 16'sd100, 16'sh8000, 16'sh8000);
        send_frame(11'h201, 16'sd2729, 16'sd0, 16'sd0);
        send_frame(11'h201, 16'sd5461, 16'sd1, -16'sd1);
        send_frame(11'h201, 16'sd2730, 16'sd2, 16'sd2);
        send_frame(11'h202, 16'sh7FFF, 16'sd1000, 16'sd1);
        send_frame(11'h202, 16'sh8000, -16'sd1000, -16'sd1);
        send_frame(11'h202, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_frame(11'h203, 16'sd5460, 16'sh7FFF, 16'sd0);
        send_frame(11'h203, 16'sd5461, 16'sh7FFF, 16'sd0);
        send_frame(11'h204, 16'sd2730, 16'sh8000, 16'sd3);
        send_frame(11'h204, 16'sd0, 16'sh8000, 16'sd4);
        send_frame(11'h204, 16'sd8191, 16'sh8000, 16'sd5);
        send_frame(11'h203, 16'sd1, 16'sh7FFF, 16'sh7FFF);
        send_frame(11'h203, 16'sd8191, 16'sh7FFF, 16'sh8000);
        send_frame(11'h203, 16'sd2, 16'sh7FFF, 16'sd7);
        for (int i = 0; i < mfu_pkg::MOTOR_COUNT_DEF; i++)
            motor_angle[i] = 16'sd100;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_until_idle();
            write_weight(phase_weight[phase]);
            if (phase == 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            else
            begin
                tx_idle_pct = 25;
                rx_idle_pct <= 25;
            end
            if (phase == 2)
                hold_req <= 1'b1;
            sent = 0;
            while (sent < PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 12)
                begin
                    id  = 11'($urandom);
                    ang = 16'($urandom);
                    spd = 16'($urandom);
                end
                else
                begin
                    m  = $urandom_range(mfu_pkg::MOTOR_COUNT_DEF - 1);
                    id = mfu_pkg::ID_BASE + 11'(m);
                    roll = $urandom_range(99);
                    if (roll < 60)
                    begin
                        step_ang = int'(motor_angle[m]) + $urandom_range(3000) - 1500;
                        ang = 16'(step_ang & 8191);
                    end
                    else if (roll < 85)
                        ang = 16'($urandom_range(8191));
                    else
                        ang = 16'($urandom);
                    motor_angle[m] = ang;
                    if ($urandom_range(99) < 10)
                        spd = speed_pick[$urandom_range(3)];
                    else
                        spd = 16'($urandom);
                end
                send_frame(id, ang, spd, 16'($urandom));
                sent++;
            end
        end

        wait_until_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
